### rtl/lzwd_pkg.sv
// shared constants and types for the lzss window decoder
package lzwd_pkg;

    localparam int WINDOW_SIZE  = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_SIZE);
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_IDX_W    = CFG_ADDR_W - 2;
    localparam int COPY_CNT_W   = 5;
    localparam int TOKEN_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0]   REG_OUTPUT_LENGTH = '0;
    localparam logic [TOKEN_CNT_W-1:0] TOKENS_PER_FLAG   = TOKEN_CNT_W'(8);
    localparam logic [COPY_CNT_W-1:0]  MATCH_LEN_BIAS    = COPY_CNT_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

### rtl/lzss_window_decoder_top.sv
// lzss decoder with 4096-byte history window, stream ports and apb register port
//
// Takes one compressed byte per input transaction and sends one decoded byte per
// output transaction. Flag bytes, literal bytes and the first byte of a match are
// taken whenever the output register is free. The second byte of a match starts
// a copy of len bytes (3 to 18): every copied byte needs a read state and a
// write state on the history ram, whose read data are registered; the write
// state waits for a free output register. No input is taken during a copy. The
// history needs no clearing pass after reset or at end of stream: the write
// pointer doubles as a fill count, and any entry not yet written in the current
// stream reads as zero. output_length (register 0, byte address 0) caps the
// number of bytes decoded per stream; the remaining bytes of the stream are
// swallowed without output. A transaction with tlast set ends the stream and
// returns the decoder to its starting state, keeping output_length.
module lzss_window_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // compressed byte input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lzwd_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] in_byte
    input  logic                                 s_axis_tlast,   // last_byte
    // decoded byte output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lzwd_pkg::BYTE_W-1:0]          m_axis_tdata,   // [7:0] out_byte
    output logic                                 m_axis_tlast,   // run_last
    output logic                                 m_axis_tuser,   // [0] stream_done
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lzwd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [lzwd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [lzwd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int AW = lzwd_pkg::WIN_AW;
    localparam int BW = lzwd_pkg::BYTE_W;

    // register file
    logic [lzwd_pkg::COUNT_W-1:0]     r_out_len;
    logic [lzwd_pkg::CFG_IDX_W-1:0]   w_cfg_idx;

    // decoder state
    lzwd_pkg::t_state                 r_state, n_state;
    logic [AW-1:0]                    r_wp, n_wp;          // write pointer and fill count
    logic                             r_wrapped, n_wrapped; // whole window written once
    logic [AW-1:0]                    r_rp, n_rp;          // copy source pointer
    logic [BW-1:0]                    r_flags, n_flags;
    logic [lzwd_pkg::TOKEN_CNT_W-1:0] r_tokens, n_tokens;
    logic                             r_await, n_await;
    logic [BW-1:0]                    r_off_lo, n_off_lo;
    logic [lzwd_pkg::COUNT_W-1:0]     r_emitted, n_emitted;
    logic [lzwd_pkg::COPY_CNT_W-1:0]  r_cnt, n_cnt;        // bytes left in the copy
    logic                             r_last_pend, n_last_pend;
    logic                             r_src_ok, n_src_ok;  // source entry written this stream

    // output register
    logic                             r_out_valid, n_out_valid;
    logic [BW-1:0]                    r_out_byte, n_out_byte;
    logic                             r_out_last, n_out_last;
    logic                             r_out_done, n_out_done;

    // history ram
    logic                             w_we, w_re;
    logic [BW-1:0]                    w_wdata, w_rdata, w_copy_byte;

    logic                             w_out_free, w_in_acc, w_active;
    logic [lzwd_pkg::COUNT_W-1:0]     w_emit_inc;
    logic [AW-1:0]                    w_dist;
    logic                             w_clear;

    // apb: always ready, write at access phase
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[lzwd_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len <= '0;
        end else if (psel && penable && pwrite && (w_cfg_idx == lzwd_pkg::REG_OUTPUT_LENGTH)) begin
            r_out_len <= pwdata;
        end
    end

    assign prdata = (w_cfg_idx == lzwd_pkg::REG_OUTPUT_LENGTH) ? r_out_len : '0;

    // handshakes
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == lzwd_pkg::ST_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_active      = r_emitted < r_out_len;
    assign w_emit_inc    = r_emitted + lzwd_pkg::COUNT_W'(1);
    assign w_dist        = {s_axis_tdata[7:4], r_off_lo};
    // entries not yet written in this stream read as zero
    assign w_copy_byte   = r_src_ok ? w_rdata : '0;

    lzwd_ram #(
        .WIDTH (BW),
        .DEPTH (lzwd_pkg::WINDOW_SIZE)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_wrapped   = r_wrapped;
        n_rp        = r_rp;
        n_flags     = r_flags;
        n_tokens    = r_tokens;
        n_await     = r_await;
        n_off_lo    = r_off_lo;
        n_emitted   = r_emitted;
        n_cnt       = r_cnt;
        n_last_pend = r_last_pend;
        n_src_ok    = r_src_ok;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_wdata     = s_axis_tdata;
        w_clear     = 1'b0;

        case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    w_clear = s_axis_tlast;
                    if (w_active) begin
                        if (r_tokens == '0) begin
                            // flag byte
                            n_flags  = s_axis_tdata;
                            n_tokens = lzwd_pkg::TOKENS_PER_FLAG;
                        end else if (r_await) begin
                            // second match byte: start the copy, hold any end of stream
                            n_rp        = r_wp - w_dist;
                            n_cnt       = lzwd_pkg::COPY_CNT_W'(s_axis_tdata[3:0])
                                          + lzwd_pkg::MATCH_LEN_BIAS;
                            n_await     = 1'b0;
                            n_flags     = {r_flags[BW-2:0], 1'b0};
                            n_tokens    = r_tokens - lzwd_pkg::TOKEN_CNT_W'(1);
                            n_last_pend = s_axis_tlast;
                            n_state     = lzwd_pkg::ST_READ;
                            w_clear     = 1'b0;
                        end else if (r_flags[BW-1]) begin
                            n_off_lo = s_axis_tdata;
                            n_await  = 1'b1;
                        end else begin
                            // literal
                            w_we        = 1'b1;
                            n_wp        = r_wp + AW'(1);
                            n_wrapped   = r_wrapped || (r_wp == '1);
                            n_emitted   = w_emit_inc;
                            n_flags     = {r_flags[BW-2:0], 1'b0};
                            n_tokens    = r_tokens - lzwd_pkg::TOKEN_CNT_W'(1);
                            n_out_valid = 1'b1;
                            n_out_byte  = s_axis_tdata;
                            n_out_last  = 1'b1;
                            n_out_done  = w_emit_inc >= r_out_len;
                        end
                    end
                end
            end
            lzwd_pkg::ST_READ: begin
                w_re     = 1'b1;
                n_src_ok = r_wrapped || (r_rp < r_wp);
                n_state  = lzwd_pkg::ST_WRITE;
            end
            lzwd_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    w_we        = 1'b1;
                    w_wdata     = w_copy_byte;
                    n_wp        = r_wp + AW'(1);
                    n_wrapped   = r_wrapped || (r_wp == '1);
                    n_rp        = r_rp + AW'(1);
                    n_emitted   = w_emit_inc;
                    n_cnt       = r_cnt - lzwd_pkg::COPY_CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out_byte  = w_copy_byte;
                    n_out_done  = w_emit_inc >= r_out_len;
                    n_out_last  = (r_cnt == lzwd_pkg::COPY_CNT_W'(1)) || n_out_done;
                    if (n_out_last) begin
                        n_state     = lzwd_pkg::ST_IDLE;
                        w_clear     = r_last_pend;
                        n_last_pend = 1'b0;
                    end else begin
                        n_state = lzwd_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = lzwd_pkg::ST_IDLE;
            end
        endcase

        // end of stream: back to the starting state, history emptied via fill count
        if (w_clear) begin
            n_wp      = '0;
            n_wrapped = 1'b0;
            n_flags   = '0;
            n_tokens  = '0;
            n_await   = 1'b0;
            n_off_lo  = '0;
            n_emitted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzwd_pkg::ST_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_flags     <= '0;
            r_tokens    <= '0;
            r_await     <= 1'b0;
            r_off_lo    <= '0;
            r_emitted   <= '0;
            r_cnt       <= '0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_wrapped   <= n_wrapped;
            r_flags     <= n_flags;
            r_tokens    <= n_tokens;
            r_await     <= n_await;
            r_off_lo    <= n_off_lo;
            r_emitted   <= n_emitted;
            r_cnt       <= n_cnt;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rp       <= n_rp;
        r_src_ok   <= n_src_ok;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

endmodule

### rtl/lzwd_ram.sv
// generic single-write, single-read ram with registered read data
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lzwd_checker.sv
// port-level checks for the lzss window decoder, bound to the top level
module lzwd_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [lzwd_pkg::BYTE_W-1:0]          m_axis_tdata,
    input  logic                                 m_axis_tlast,
    input  logic                                 m_axis_tuser
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    // the byte that reaches the length limit always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("stream_done without run_last");

    // no input taken while a decoded byte is stuck
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind lzss_window_decoder_top lzwd_checker u_lzwd_checker (.*);
